@@ hdl/shpid_pkg.sv @@
package shpid_pkg;

	localparam int FRAC_BITS = 16;

	// apb map: register i at byte address 4*i
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_TARGET_X       = 3'd0;
	localparam logic [2:0] REG_TARGET_HEADING = 3'd1;
	localparam logic [2:0] REG_SURGE_GAIN_P   = 3'd2;
	localparam logic [2:0] REG_SURGE_GAIN_I   = 3'd3;
	localparam logic [2:0] REG_SURGE_GAIN_D   = 3'd4;
	localparam logic [2:0] REG_HEADING_GAIN_P = 3'd5;
	localparam logic [2:0] REG_HEADING_GAIN_I = 3'd6;
	localparam logic [2:0] REG_HEADING_GAIN_D = 3'd7;

	// constants held as value * 2^32, rounded to FRAC_BITS
	localparam longint unsigned PI_X32     = 64'd13493037705;
	localparam longint unsigned TWO_PI_X32 = 64'd26986075409;
	localparam longint unsigned C314_X32   = 64'd13486197309;
	localparam longint unsigned C08_X32    = 64'd3435973837;
	localparam longint unsigned RND_X32    = 64'd1 << (31 - FRAC_BITS);

	localparam int CW = 36;
	localparam logic signed [CW-1:0] Q_PI =
		CW'((PI_X32 + RND_X32) >> (32 - FRAC_BITS));
	localparam logic signed [CW-1:0] Q_TWO_PI =
		CW'((TWO_PI_X32 + RND_X32) >> (32 - FRAC_BITS));
	localparam logic signed [CW-1:0] Q_FIN_LIM =
		CW'((C314_X32 + RND_X32) >> (32 - FRAC_BITS));
	localparam logic signed [CW-1:0] Q_DEAD =
		CW'((C08_X32 + RND_X32) >> (32 - FRAC_BITS));
	localparam logic signed [CW-1:0] Q_THRUST_LIM = CW'(64'd5 << FRAC_BITS);

	// sample skipped when dt * 1e6 < 2^F, i.e. dt below this bound
	localparam logic [31:0] SKIP_LIM =
		32'(((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000);

	// product, rounded term, accumulator, dividend and step counter widths
	localparam int PW  = 66;
	localparam int RW  = PW - FRAC_BITS;
	localparam int UW  = RW + 2;
	localparam int NW  = 33 + FRAC_BITS + 1;
	localparam int NCW = $clog2(NW + 1);

	// datapath operation codes
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_PREP  = 4'd2;
	localparam logic [3:0] OP_WRAP  = 4'd3;
	localparam logic [3:0] OP_DLOAD = 4'd4;
	localparam logic [3:0] OP_DSTEP = 4'd5;
	localparam logic [3:0] OP_MEDT  = 4'd6;
	localparam logic [3:0] OP_INT   = 4'd7;
	localparam logic [3:0] OP_MKP   = 4'd8;
	localparam logic [3:0] OP_MKI   = 4'd9;
	localparam logic [3:0] OP_MKD   = 4'd10;
	localparam logic [3:0] OP_FIN   = 4'd11;
	localparam logic [3:0] OP_PUSH  = 4'd12;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [18:0] target_heading;
		logic [30:0]        surge_gain_p;
		logic [30:0]        surge_gain_i;
		logic [30:0]        surge_gain_d;
		logic [30:0]        heading_gain_p;
		logic [30:0]        heading_gain_i;
		logic [30:0]        heading_gain_d;
	} cfg_t;

	typedef struct packed {
		logic [3:0] op;
		logic       loop_sel;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic wrapped;
		logic div_last;
		logic out_free;
	} stat_t;

	// >> FRAC_BITS, nearest, ties away from zero
	function automatic logic signed [RW-1:0] rnd_shr(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = v + (v[PW-1] ? ((PW'(1) << (FRAC_BITS - 1)) - PW'(1))
		                 : (PW'(1) << (FRAC_BITS - 1)));
		return RW'(t >>> FRAC_BITS);
	endfunction

endpackage

@@ hdl/shpid_regs.sv @@
module shpid_regs import shpid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic [2:0] idx;

	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x       <= 32'sd786432;
			cfg_q.target_heading <= -19'sd154415;
			cfg_q.surge_gain_p   <= 31'd524288;
			cfg_q.surge_gain_i   <= 31'd26214;
			cfg_q.surge_gain_d   <= 31'd19661;
			cfg_q.heading_gain_p <= 31'd65536;
			cfg_q.heading_gain_i <= 31'd6554;
			cfg_q.heading_gain_d <= 31'd13107;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_TARGET_X:       cfg_q.target_x       <= pwdata;
				REG_TARGET_HEADING: cfg_q.target_heading <= pwdata[18:0];
				REG_SURGE_GAIN_P:   cfg_q.surge_gain_p   <= pwdata[30:0];
				REG_SURGE_GAIN_I:   cfg_q.surge_gain_i   <= pwdata[30:0];
				REG_SURGE_GAIN_D:   cfg_q.surge_gain_d   <= pwdata[30:0];
				REG_HEADING_GAIN_P: cfg_q.heading_gain_p <= pwdata[30:0];
				REG_HEADING_GAIN_I: cfg_q.heading_gain_i <= pwdata[30:0];
				REG_HEADING_GAIN_D: cfg_q.heading_gain_d <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET_X:       prdata = cfg_q.target_x;
			REG_TARGET_HEADING: prdata = 32'(cfg_q.target_heading);
			REG_SURGE_GAIN_P:   prdata = {1'b0, cfg_q.surge_gain_p};
			REG_SURGE_GAIN_I:   prdata = {1'b0, cfg_q.surge_gain_i};
			REG_SURGE_GAIN_D:   prdata = {1'b0, cfg_q.surge_gain_d};
			REG_HEADING_GAIN_P: prdata = {1'b0, cfg_q.heading_gain_p};
			REG_HEADING_GAIN_I: prdata = {1'b0, cfg_q.heading_gain_i};
			REG_HEADING_GAIN_D: prdata = {1'b0, cfg_q.heading_gain_d};
			default:            prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/shpid_ctrl.sv @@
module shpid_ctrl import shpid_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_WRAP  = 4'd2;
	localparam logic [3:0] S_DLOAD = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_MEDT  = 4'd5;
	localparam logic [3:0] S_INT   = 4'd6;
	localparam logic [3:0] S_MKP   = 4'd7;
	localparam logic [3:0] S_MKI   = 4'd8;
	localparam logic [3:0] S_MKD   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       loop_q, loop_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		loop_d       = loop_q;
		cmd.op       = OP_NONE;
		cmd.loop_sel = loop_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.op  = OP_PREP;
				loop_d  = 1'b0;
				state_d = st.skip ? S_IDLE : S_WRAP;
			end
			S_WRAP: begin
				cmd.op = OP_WRAP;
				if (st.wrapped) state_d = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.op  = OP_DLOAD;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DSTEP;
				if (st.div_last) state_d = S_MEDT;
			end
			S_MEDT: begin
				cmd.op  = OP_MEDT;
				state_d = S_INT;
			end
			S_INT: begin
				cmd.op  = OP_INT;
				state_d = S_MKP;
			end
			S_MKP: begin
				cmd.op  = OP_MKP;
				state_d = S_MKI;
			end
			S_MKI: begin
				cmd.op  = OP_MKI;
				state_d = S_MKD;
			end
			S_MKD: begin
				cmd.op  = OP_MKD;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.op = OP_FIN;
				if (loop_q) begin
					state_d = S_OUT;
				end else begin
					loop_d  = 1'b1;
					state_d = S_DLOAD;
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.op  = OP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			loop_q  <= loop_d;
		end
	end

endmodule

@@ hdl/shpid_dp.sv @@
module shpid_dp import shpid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [87:0] in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [39:0] out_data
);

	logic signed [31:0]    pos_q;
	logic signed [18:0]    yaw_q;
	logic [31:0]           dt_q;
	logic signed [31:0]    e0_q;
	logic                  dead_q;
	logic signed [CW-1:0]  ey_q;
	logic signed [31:0]    prev_q [2];
	logic signed [31:0]    integ_q [2];
	logic [NW-1:0]         num_q;
	logic [31:0]           rem_q;
	logic [NCW-1:0]        dcnt_q;
	logic                  neg_q;
	logic signed [31:0]    deriv_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [UW-1:0]  u_q;
	logic signed [19:0]    thrust_q;
	logic signed [18:0]    fin_q;
	logic                  ovalid_q;
	logic [39:0]           odata_q;

	logic                  l;
	logic signed [32:0]    ex;
	logic signed [31:0]    cur_e;
	logic signed [32:0]    diff;
	logic [32:0]           mag;
	logic [32:0]           rem_sh;
	logic                  ge;
	logic signed [31:0]    deriv_d;
	logic signed [32:0]    mul_a, mul_b;
	logic signed [UW-1:0]  isum, u_tot, u_neg;
	logic signed [31:0]    isat;
	logic [30:0]           kp, ki, kd;

	assign l     = cmd.loop_sel;
	assign ex    = $signed({cfg.target_x[31], cfg.target_x}) - $signed({pos_q[31], pos_q});
	assign cur_e = l ? ey_q[31:0] : e0_q;
	assign diff  = $signed({cur_e[31], cur_e}) - $signed({prev_q[l][31], prev_q[l]});
	assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, dt_q};
	assign kp = l ? cfg.heading_gain_p : cfg.surge_gain_p;
	assign ki = l ? cfg.heading_gain_i : cfg.surge_gain_i;
	assign kd = l ? cfg.heading_gain_d : cfg.surge_gain_d;

	// quotient saturated into 32 bits with the stored sign
	always_comb begin
		if (|num_q[NW-1:31])
			deriv_d = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			deriv_d = neg_q ? -$signed({1'b0, num_q[30:0]})
			                :  $signed({1'b0, num_q[30:0]});
	end

	always_comb begin
		mul_a = {cur_e[31], cur_e};
		mul_b = {1'b0, dt_q};
		unique case (cmd.op)
			OP_MKP: mul_b = {2'b00, kp};
			OP_MKI: begin
				mul_a = {integ_q[l][31], integ_q[l]};
				mul_b = {2'b00, ki};
			end
			OP_MKD: begin
				mul_a = {deriv_q[31], deriv_q};
				mul_b = {2'b00, kd};
			end
			default: ;
		endcase
	end

	always_comb begin
		isum = UW'(integ_q[l]) + UW'(rnd_shr(prod_q));
		if (isum > UW'(32'sh7fff_ffff))      isat = 32'sh7fff_ffff;
		else if (isum < UW'(32'sh8000_0000)) isat = 32'sh8000_0000;
		else                                 isat = isum[31:0];
		u_tot = u_q + UW'(rnd_shr(prod_q));
		u_neg = -u_tot;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				pos_q <= in_data[31:0];
				yaw_q <= in_data[50:32];
				dt_q  <= in_data[82:51];
			end
			OP_PREP: begin
				if (ex > 33'sh0_7fff_ffff)       e0_q <= 32'sh7fff_ffff;
				else if (ex < -33'sh0_8000_0000) e0_q <= 32'sh8000_0000;
				else                             e0_q <= ex[31:0];
				dead_q <= (ex <= Q_DEAD) && (ex >= -Q_DEAD);
				ey_q   <= CW'(cfg.target_heading) - CW'(yaw_q);
			end
			OP_WRAP: begin
				if (ey_q > Q_PI)       ey_q <= ey_q - Q_TWO_PI;
				else if (ey_q < -Q_PI) ey_q <= ey_q + Q_TWO_PI;
			end
			OP_DLOAD: begin
				num_q <= (NW'(mag) << FRAC_BITS) + NW'(dt_q >> 1);
				rem_q <= 32'd0;
				neg_q <= diff[32];
			end
			OP_DSTEP: begin
				rem_q <= ge ? 32'(rem_sh - {1'b0, dt_q}) : rem_sh[31:0];
				num_q <= {num_q[NW-2:0], ge};
			end
			OP_MEDT, OP_MKP: prod_q <= mul_a * mul_b;
			OP_INT: deriv_q <= deriv_d;
			OP_MKI: begin
				u_q    <= UW'(rnd_shr(prod_q));
				prod_q <= mul_a * mul_b;
			end
			OP_MKD: begin
				u_q    <= u_tot;
				prod_q <= mul_a * mul_b;
			end
			OP_FIN: begin
				if (!l) begin
					if (dead_q)                   thrust_q <= 20'sd0;
					else if (u_neg > Q_THRUST_LIM)  thrust_q <= 20'(Q_THRUST_LIM);
					else if (u_neg < -Q_THRUST_LIM) thrust_q <= 20'(-Q_THRUST_LIM);
					else                            thrust_q <= u_neg[19:0];
				end else begin
					if (u_tot > Q_FIN_LIM)       fin_q <= 19'(-Q_FIN_LIM);
					else if (u_tot < -Q_FIN_LIM) fin_q <= 19'(Q_FIN_LIM);
					else                         fin_q <= u_neg[18:0];
				end
			end
			OP_PUSH: odata_q <= {fin_q, thrust_q};
			default: ;
		endcase
	end

	// loop state, divide step counter and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q[0]  <= '0;
			prev_q[1]  <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			dcnt_q     <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (cmd.op == OP_INT) begin
				integ_q[l] <= isat;
				prev_q[l]  <= cur_e;
			end
			if (cmd.op == OP_DLOAD)
				dcnt_q <= NCW'(NW);
			else if (cmd.op == OP_DSTEP)
				dcnt_q <= dcnt_q - NCW'(1);
			if (cmd.op == OP_PUSH)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	assign st.skip     = dt_q < SKIP_LIM;
	assign st.wrapped  = !(ey_q > Q_PI) && !(ey_q < -Q_PI);
	assign st.div_last = (dcnt_q == NCW'(1));
	assign st.out_free = !ovalid_q || out_ready;

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

`ifndef ASSERT_OFF
	a_int_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INT) |-> (dcnt_q == '0))
		else $error("integral step before division finished");
	a_thrust_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> (CW'(thrust_q) <= Q_THRUST_LIM && CW'(thrust_q) >= -Q_THRUST_LIM))
		else $error("thrust outside clamp");
	a_fin_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> (CW'(fin_q) <= Q_FIN_LIM && CW'(fin_q) >= -Q_FIN_LIM))
		else $error("fin angle outside clamp");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PUSH) |-> (!ovalid_q || out_ready))
		else $error("result overwritten before taken");
`endif

endmodule

@@ hdl/surge_and_heading_pid_controller.sv @@
// surge and heading pid controller with output clamps
//
// s_* channel: one transaction per odometry sample (x position, yaw, time since
// the previous sample). s_tready is high only while no sample is in work.
// m_* channel: one transaction per sample, thrust and fin command. a sample
// whose time step is below one microsecond gives no transaction and leaves
// the loop state as it was.
// apb port: gains and targets, written between samples; pready always high.
//
// the bit-serial derivative divider takes 50 steps per loop and runs once for
// the surge loop and once for heading; the heading error wrap step adds to the
// time from accept to m_tvalid when a wrap is needed. the multiplies share one
// 33x33 multiplier. one sample is in work at a time, so a new sample is taken
// only once the last result is in the output register; a skipped sample frees
// the input again after the prep step.
// the finished result waits in an output register, so the next sample is
// accepted while m_tvalid is still high; a stalled receiver holds the block
// only when the next result is ready to be written.
// reset clears both loop integrals and previous errors and loads the default
// gains and targets.
module surge_and_heading_pid_controller import shpid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [87:0]       s_tdata,  // position_x, measured_yaw, elapsed_time
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,  // thrust, fin_angle
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	assign pready = 1'b1;

	// configuration registers
	shpid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer: one op per cycle to the datapath while busy, stalled by a full output
	shpid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// errors, divider, shared multiplier, loop state and output register
	shpid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import shpid_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 150;
	localparam int HOLD_CYCLES    = 500;

	typedef struct {
		logic signed [19:0] thrust;
		logic signed [18:0] fin_angle;
	} command_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [87:0]       s_tdata;  // position_x, measured_yaw, elapsed_time, zero pad
	logic              m_tvalid;
	logic              m_tready;
	logic [39:0]       m_tdata;  // thrust, fin_angle, zero pad
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// predictor copy of the registers and loop state
	longint tgt_x, tgt_heading;
	longint gain_sp, gain_si, gain_sd, gain_hp, gain_hi, gain_hd;
	longint surge_prev, surge_integ, heading_prev, heading_integ;

	command_t expected_cmds[$];
	int       errors;
	bit       idle_on;
	bit       hold_req;
	int       quiet_cycles;

	surge_and_heading_pid_controller dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clamp_to(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// shift right by the fraction width, nearest, ties away from zero
	function automatic longint round_shift(input longint v);
		longint unsigned m;
		longint unsigned r;
		m = (v < 0) ? longint'(0) - v : v;
		r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint pid_update(inout longint prev, inout longint integ,
			input longint e, input longint unsigned dt,
			input longint kp, input longint ki, input longint kd);
		longint diff;
		longint unsigned mag;
		longint unsigned q;
		longint deriv;
		diff = e - prev;
		mag = (diff < 0) ? longint'(0) - diff : diff;
		q = ((mag << FRAC_BITS) + (dt >> 1)) / dt;
		if (q > 64'h8000_0000) q = 64'h8000_0000;
		deriv = sat32((diff < 0) ? -longint'(q) : longint'(q));
		integ = sat32(integ + round_shift(e * longint'(dt)));
		prev = e;
		return round_shift(kp * e) + round_shift(ki * integ) + round_shift(kd * deriv);
	endfunction

	// works out the command for one sample; returns 0 when the sample is skipped
	function automatic bit predict_command(input logic [31:0] pos_bits,
			input logic [18:0] yaw_bits, input logic [31:0] dt_bits,
			output command_t cmd);
		longint pos, yaw, ex, ex_abs, ey, u, thr;
		longint unsigned dt;
		pos = longint'($signed(pos_bits));
		yaw = longint'($signed(yaw_bits));
		dt  = dt_bits;
		if (dt * 64'd1000000 < (64'd1 << FRAC_BITS)) return 1'b0;
		ex = tgt_x - pos;
		ex_abs = (ex < 0) ? -ex : ex;
		u = pid_update(surge_prev, surge_integ, sat32(ex), dt, gain_sp, gain_si, gain_sd);
		thr = clamp_to(-u, longint'(Q_THRUST_LIM));
		if (ex_abs <= longint'(Q_DEAD)) thr = 0;
		ey = tgt_heading - yaw;
		while (ey > longint'(Q_PI)) ey -= longint'(Q_TWO_PI);
		while (ey < -longint'(Q_PI)) ey += longint'(Q_TWO_PI);
		u = pid_update(heading_prev, heading_integ, ey, dt, gain_hp, gain_hi, gain_hd);
		cmd.thrust = 20'(thr);
		cmd.fin_angle = 19'(-clamp_to(u, longint'(Q_FIN_LIM)));
		return 1'b1;
	endfunction

	// apb write: setup cycle then access cycle, predictor updated alongside
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TARGET_X:       tgt_x = longint'($signed(value));
			REG_TARGET_HEADING: tgt_heading = longint'($signed(value[18:0]));
			REG_SURGE_GAIN_P:   gain_sp = value[30:0];
			REG_SURGE_GAIN_I:   gain_si = value[30:0];
			REG_SURGE_GAIN_D:   gain_sd = value[30:0];
			REG_HEADING_GAIN_P: gain_hp = value[30:0];
			REG_HEADING_GAIN_I: gain_hi = value[30:0];
			default:            gain_hd = value[30:0];
		endcase
	endtask

	// one sample on the slave side; tvalid stays high for a following sample
	task automatic send_sample(input logic [31:0] pos, input logic [18:0] yaw,
			input logic [31:0] dt);
		command_t cmd;
		if (idle_on && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 38);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, dt, yaw, pos};
		do @(posedge clk); while (!s_tready);
		if (predict_command(pos, yaw, dt, cmd)) expected_cmds.push_back(cmd);
	endtask

	// sender pauses until every command is back and the block has gone quiet
	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sample with random content, mostly near the target and with short time steps
	task automatic send_random_sample;
		logic [31:0] pos;
		logic [18:0] yaw;
		logic [31:0] dt;
		case ($urandom_range(9))
			0:       pos = $urandom;
			1, 2:    pos = 32'(tgt_x + $signed(32'($urandom_range(131072))) - 65536);
			default: pos = 32'(tgt_x + $signed(32'($urandom_range(2000000))) - 1000000);
		endcase
		yaw = ($urandom_range(7) == 0) ? 19'($urandom)
			: 19'(longint'($urandom_range(411774)) - 205887);
		case ($urandom_range(19))
			0:       dt = 32'd0;
			1, 2:    dt = $urandom;
			3:       dt = $urandom_range(4);
			default: dt = $urandom_range(196608, 1);
		endcase
		send_sample(pos, yaw, dt);
	endtask

	task automatic run_random(input int count);
		repeat (count) send_random_sample();
		drain();
	endtask

	task automatic test_directed;
		send_sample(32'h8000_0000, 19'sd0, 32'd65536);          // most negative position
		send_sample(32'h7FFF_FFFF, 19'h3FFFF, 32'hFFFF_FFFF);   // most positive, longest step
		send_sample(32'd786432, 19'sd0, 32'd0);                 // zero step is skipped
		send_sample(32'd786432, -19'sd205887, 32'd1);           // shortest step
		send_sample(32'(786432 + 52429), 19'sd205887, 32'd6554); // dead-band edge
		send_sample(32'(786432 - 52429), 19'sd0, 32'd6554);
		send_sample(32'(786432 + 52430), 19'sd0, 32'd6554);     // just outside
		send_sample(32'(786432 - 52430), 19'sd0, 32'd6554);
		send_sample(32'd0, 19'h40000, 32'd65536);               // most negative yaw; the next, most positive, wraps
		send_sample(32'd0, 19'h3FFFF, 32'd65536);
		send_sample(32'hF000_0000, 19'sd100000, 32'd1);         // derivative saturates
		send_sample(32'h1000_0000, -19'sd100000, 32'd1);
		send_sample(32'h5555_5555, 19'h2AAAA, 32'hAAAA_AAAA);   // alternating bits
		send_sample(32'hAAAA_AAAA, 19'h55555, 32'h5555_5555);
		send_sample(32'd786432, 19'sd0, 32'd0);
		send_sample(32'd100, 19'sd5, 32'd655360);
		drain();
	endtask

	// receiver holds off while samples keep coming, so the block stalls its input
	task automatic test_backpressure;
		hold_req = 1'b1;
		repeat (12) send_random_sample();
		drain();
		// pause until all commands are home, then carry on
		repeat (20) send_random_sample();
		drain();
	endtask

	task automatic test_config_sweep;
		// extremes: largest gains and targets
		write_reg(REG_TARGET_X, 32'h7FFF_FFFF);
		write_reg(REG_TARGET_HEADING, 32'(205887));
		write_reg(REG_SURGE_GAIN_P, 32'hFFFF_FFFF);
		write_reg(REG_SURGE_GAIN_I, 32'h7FFF_FFFF);
		write_reg(REG_SURGE_GAIN_D, 32'h7FFF_FFFF);
		write_reg(REG_HEADING_GAIN_P, 32'h7FFF_FFFF);
		write_reg(REG_HEADING_GAIN_I, 32'hFFFF_FFFF);
		write_reg(REG_HEADING_GAIN_D, 32'h7FFF_FFFF);
		run_random(200);
		// zero gains, smallest targets
		write_reg(REG_TARGET_X, 32'h8000_0000);
		write_reg(REG_TARGET_HEADING, 32'hFFFC_DBC1);
		write_reg(REG_SURGE_GAIN_P, 32'h8000_0000);
		write_reg(REG_SURGE_GAIN_I, 32'd0);
		write_reg(REG_SURGE_GAIN_D, 32'd0);
		write_reg(REG_HEADING_GAIN_P, 32'd0);
		write_reg(REG_HEADING_GAIN_I, 32'd0);
		write_reg(REG_HEADING_GAIN_D, 32'd0);
		run_random(150);
		// several random settings: moderate gains, but a fully random heading d gain
		repeat (3) begin
			write_reg(REG_TARGET_X, $urandom_range(4000000) - 2000000);
			write_reg(REG_TARGET_HEADING, $urandom);
			write_reg(REG_SURGE_GAIN_P, $urandom_range(1 << 21));
			write_reg(REG_SURGE_GAIN_I, $urandom_range(1 << 18));
			write_reg(REG_SURGE_GAIN_D, $urandom_range(1 << 18));
			write_reg(REG_HEADING_GAIN_P, $urandom_range(1 << 20));
			write_reg(REG_HEADING_GAIN_I, $urandom_range(1 << 17));
			write_reg(REG_HEADING_GAIN_D, $urandom);
			run_random(250);
		end
	endtask

	task automatic test_no_idle;
		idle_on = 1'b0;
		run_random(300);
		idle_on = 1'b1;
	endtask

	// result side: compare each command, then pick the next tready
	always @(posedge clk) begin
		command_t want;
		int hold_left;
		if (m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				$error("unexpected command transaction: %h", m_tdata);
				errors++;
			end else begin
				want = expected_cmds.pop_front();
				if ($signed(m_tdata[19:0]) !== want.thrust) begin
					$error("thrust: expected %0d, got %0d", want.thrust,
						$signed(m_tdata[19:0]));
					errors++;
				end
				if ($signed(m_tdata[38:20]) !== want.fin_angle) begin
					$error("fin_angle: expected %0d, got %0d", want.fin_angle,
						$signed(m_tdata[38:20]));
					errors++;
				end
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < 38);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		quiet_cycles = 0;
		// predictor defaults match the block after reset
		tgt_x = 786432;
		tgt_heading = -154415;
		gain_sp = 524288;
		gain_si = 26214;
		gain_sd = 19661;
		gain_hp = 65536;
		gain_hi = 6554;
		gain_hd = 13107;
		surge_prev = 0;
		surge_integ = 0;
		heading_prev = 0;
		heading_integ = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		run_random(450);
		test_backpressure();
		test_no_idle();
		test_config_sweep();

		drain();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ surge_and_heading_pid_controller.f @@
hdl/shpid_pkg.sv
hdl/shpid_regs.sv
hdl/shpid_ctrl.sv
hdl/shpid_dp.sv
hdl/surge_and_heading_pid_controller.sv
verif/testbench.sv
